/* rtl/kalock_pkg.sv */
// ----------------------------------------------------------------------------
// kalock_pkg
// Shared types, event codes, register map and reset values of the keypad
// access level lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kalock_pkg;

  // keys a code may hold, each in a 4-bit slot
  localparam int unsigned KAL_MAX_KEYS   = 4;
  localparam int unsigned CODE_SLOTS     = 4;
  localparam int unsigned KEY_W          = 4;

  // configuration port geometry
  localparam int unsigned CFG_ADDR_W     = 5;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  // field widths
  localparam int unsigned FUNC_W         = 4;
  localparam int unsigned LEVEL_W        = 2;
  localparam int unsigned COUNT_W        = 3;
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned LEN_W          = 3;
  localparam int unsigned IDLE_W         = 24;

  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE_GUEST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_USER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ADMIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

  // register reset values
  localparam logic [CODE_W-1:0] RST_CODE_GUEST   = 16'h0111;
  localparam logic [CODE_W-1:0] RST_CODE_USER    = 16'h0222;
  localparam logic [CODE_W-1:0] RST_CODE_ADMIN   = 16'h0333;
  localparam logic [LEN_W-1:0]  RST_CODE_LENGTH  = 3'd3;
  localparam logic [IDLE_W-1:0] RST_IDLE_TIMEOUT = 24'd600000;

  // access levels
  localparam logic [LEVEL_W-1:0] LVL_GUEST = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_USER  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ADMIN = 2'd2;

  // event codes
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 4'd0,
    FN_START  = 4'd1,
    FN_STOP   = 4'd2,
    FN_KEY    = 4'd3,
    FN_REMOVE = 4'd4,
    FN_CLEAR  = 4'd5,
    FN_TRY    = 4'd6,
    FN_LOGOUT = 4'd7,
    FN_TOUCH  = 4'd8
  } func_t;

  // configuration handed from the register file to the core
  typedef struct packed {
    logic [CODE_W-1:0] code_guest;
    logic [CODE_W-1:0] code_user;
    logic [CODE_W-1:0] code_admin;
    logic [LEN_W-1:0]  code_length;
    logic [IDLE_W-1:0] idle_timeout;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [LEVEL_W-1:0] access_level;
    logic               login_active;
    logic [COUNT_W-1:0] entry_count;
    logic               login_ok;
    logic               login_failed;
    logic               auto_logout;
    logic               may_reset;
  } res_t;

endpackage

`default_nettype wire

/* rtl/kalock_ifs.sv */
// ----------------------------------------------------------------------------
// kalock channel interfaces
// Valid/ready channels for keypad events and for lock status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kalock_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [3:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface kalock_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] access_level;
  logic       login_active;
  logic [2:0] entry_count;
  logic       login_ok;
  logic       login_failed;
  logic       auto_logout;
  logic       may_reset;

  modport source (output valid, output access_level, output login_active,
                  output entry_count, output login_ok, output login_failed,
                  output auto_logout, output may_reset, input ready);
  modport sink   (input valid, input access_level, input login_active,
                  input entry_count, input login_ok, input login_failed,
                  input auto_logout, input may_reset, output ready);
endinterface

`default_nettype wire

/* rtl/keypad_access_level_lock.sv */
// ----------------------------------------------------------------------------
// keypad_access_level_lock
// Keypad code lock with guest, user and admin levels, login entry of up to
// MAX_KEYS keys, code compare and automatic logout on idle ticks.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_ch    in         valid/ready        func, key_code
//  out_ch   out        valid/ready        access_level, login_active,
//                                         entry_count, login_ok,
//                                         login_failed, auto_logout, may_reset
//  cfg_*    in         apb write/read     code_guest, code_user, code_admin,
//                                         code_length, idle_timeout
//
//  one event is accepted per cycle unless the result is stalled; its result
//  is offered from the result register, which follows the event register
//  all decode and code compare sits between the event and result registers
//  synchronous active-low reset sets guest level, no entry, idle count zero
//  a stalled result holds the result register and one further event waits
//  in the event register
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_access_level_lock #(
  parameter int unsigned MAX_KEYS = kalock_pkg::KAL_MAX_KEYS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  kalock_in_if.sink                              in_ch,
  kalock_out_if.source                           out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [kalock_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [kalock_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [kalock_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                   cfg_pready
);
  import kalock_pkg::*;

  cfg_t cfg;

  // configuration registers
  kalock_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // event processing
  kalock_core #(
    .MAX_KEYS (MAX_KEYS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/kalock_cfg.sv */
// ----------------------------------------------------------------------------
// kalock_cfg
// APB register file holding the three codes, the code length and the idle
// timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module kalock_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [kalock_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [kalock_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [kalock_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                   cfg_pready,
  output kalock_pkg::cfg_t                       cfg_o
);
  import kalock_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] reg_idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_guest   <= RST_CODE_GUEST;
      cfg_r.code_user    <= RST_CODE_USER;
      cfg_r.code_admin   <= RST_CODE_ADMIN;
      cfg_r.code_length  <= RST_CODE_LENGTH;
      cfg_r.idle_timeout <= RST_IDLE_TIMEOUT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CODE_GUEST:   cfg_r.code_guest   <= cfg_pwdata[CODE_W-1:0];
        REG_CODE_USER:    cfg_r.code_user    <= cfg_pwdata[CODE_W-1:0];
        REG_CODE_ADMIN:   cfg_r.code_admin   <= cfg_pwdata[CODE_W-1:0];
        REG_CODE_LENGTH:  cfg_r.code_length  <= cfg_pwdata[LEN_W-1:0];
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout <= cfg_pwdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    cfg_prdata = '0;
    case (reg_idx)
      REG_CODE_GUEST:   cfg_prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, cfg_r.code_guest};
      REG_CODE_USER:    cfg_prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, cfg_r.code_user};
      REG_CODE_ADMIN:   cfg_prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, cfg_r.code_admin};
      REG_CODE_LENGTH:  cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg_r.code_length};
      REG_IDLE_TIMEOUT: cfg_prdata = {{(CFG_DATA_W-IDLE_W){1'b0}}, cfg_r.idle_timeout};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/kalock_core.sv */
// ----------------------------------------------------------------------------
// kalock_core
// Event register, lock state update and result register. One event is
// decoded and applied per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kalock_core #(
  parameter int unsigned MAX_KEYS = kalock_pkg::KAL_MAX_KEYS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  kalock_pkg::cfg_t cfg_i,
  kalock_in_if.sink        in_ch,
  kalock_out_if.source     out_ch
);
  import kalock_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int unsigned KIDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_KEYS);

  // event register
  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [KEY_W-1:0]  s1_key_r;

  // lock state
  logic [LEVEL_W-1:0] level_r,  level_nxt;
  logic               active_r, active_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [IDLE_W-1:0]  idle_r,   idle_nxt;
  logic [KEY_W-1:0]   entry_keys_r [MAX_KEYS];

  // result register
  logic out_valid_r;
  res_t res_r, res_nxt;

  logic in_fire, adv, key_wr;
  logic [IDLE_W-1:0] idle_inc;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic len_ok;
  logic [CODE_SLOTS-1:0] eq_guest, eq_user, eq_admin;
  logic hit_guest, hit_user, hit_admin;

  // handshake
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_ch.func;
      s1_key_r  <= in_ch.key_code;
    end
  end

  // code compare, one slot per key position
  for (genvar i = 0; i < CODE_SLOTS; i++) begin : g_slot
    logic used;
    assign used = cfg_i.code_length > LEN_W'(i);
    if (i < MAX_KEYS) begin : g_held
      assign eq_guest[i] = !used || (entry_keys_r[i] == cfg_i.code_guest[KEY_W*i +: KEY_W]);
      assign eq_user[i]  = !used || (entry_keys_r[i] == cfg_i.code_user[KEY_W*i +: KEY_W]);
      assign eq_admin[i] = !used || (entry_keys_r[i] == cfg_i.code_admin[KEY_W*i +: KEY_W]);
    end else begin : g_none
      assign eq_guest[i] = !used;
      assign eq_user[i]  = !used;
      assign eq_admin[i] = !used;
    end
  end

  assign len_ok = (cfg_i.code_length != '0)
               && (cfg_i.code_length <= LEN_W'(CODE_SLOTS))
               && (CMP_W'(count_r) == CMP_W'(cfg_i.code_length));
  assign hit_guest = len_ok && (&eq_guest);
  assign hit_user  = len_ok && (&eq_user);
  assign hit_admin = len_ok && (&eq_admin);

  // saturating idle count for ticks
  assign idle_inc = (idle_r != IDLE_MAX) ? idle_r + IDLE_W'(1) : idle_r;

  // next state and result
  always_comb begin
    level_nxt  = level_r;
    active_nxt = active_r;
    count_nxt  = count_r;
    idle_nxt   = idle_r;
    key_wr     = 1'b0;
    res_nxt    = '0;
    case (s1_func_r)
      FN_TICK: begin
        idle_nxt = idle_inc;
        if (level_r != LVL_GUEST && idle_inc > cfg_i.idle_timeout) begin
          level_nxt           = LVL_GUEST;
          active_nxt          = 1'b0;
          count_nxt           = '0;
          res_nxt.auto_logout = 1'b1;
        end
      end
      FN_START: begin
        active_nxt = 1'b1;
        count_nxt  = '0;
        idle_nxt   = '0;
      end
      FN_STOP: begin
        active_nxt = 1'b0;
        count_nxt  = '0;
      end
      FN_KEY: begin
        idle_nxt = '0;
        if (active_r && count_r < CNT_FULL) begin
          key_wr    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        idle_nxt = '0;
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      FN_TRY: begin
        idle_nxt  = '0;
        count_nxt = '0;
        if (hit_guest || hit_user || hit_admin) begin
          active_nxt       = 1'b0;
          res_nxt.login_ok = 1'b1;
          if (hit_guest) begin
            level_nxt = LVL_GUEST;
          end else if (hit_user) begin
            level_nxt = LVL_USER;
          end else begin
            level_nxt = LVL_ADMIN;
          end
        end else begin
          res_nxt.login_failed = 1'b1;
        end
      end
      FN_LOGOUT: begin
        level_nxt  = LVL_GUEST;
        active_nxt = 1'b0;
        count_nxt  = '0;
      end
      FN_TOUCH: begin
        idle_nxt = '0;
      end
      default: ;
    endcase
    count_ext            = {{COUNT_W{1'b0}}, count_nxt};
    res_nxt.access_level = level_nxt;
    res_nxt.login_active = active_nxt;
    res_nxt.entry_count  = count_ext[COUNT_W-1:0];
    res_nxt.may_reset    = (level_nxt != LVL_GUEST);
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LVL_GUEST;
      active_r    <= 1'b0;
      count_r     <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        level_r     <= level_nxt;
        active_r    <= active_nxt;
        count_r     <= count_nxt;
        idle_r      <= idle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // key store, no reset
  always_ff @(posedge clk) begin
    if (adv && key_wr) begin
      entry_keys_r[count_r[KIDX_W-1:0]] <= s1_key_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.access_level = res_r.access_level;
  assign out_ch.login_active = res_r.login_active;
  assign out_ch.entry_count  = res_r.entry_count;
  assign out_ch.login_ok     = res_r.login_ok;
  assign out_ch.login_failed = res_r.login_failed;
  assign out_ch.auto_logout  = res_r.auto_logout;
  assign out_ch.may_reset    = res_r.may_reset;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("key count above capacity");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    level_r != 2'd3)
    else $error("access level holds an unused code");

  a_try_flags: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_func_r == FN_TRY |=> res_r.login_ok != res_r.login_failed)
    else $error("try result must be exactly one of ok and failed");

  a_auto_logout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.auto_logout |-> res_r.access_level == LVL_GUEST
      && !res_r.login_active && res_r.entry_count == '0)
    else $error("automatic logout left level or entry set");

  a_may_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.may_reset == (res_r.access_level != LVL_GUEST))
    else $error("may_reset disagrees with access level");

endmodule

`default_nettype wire
